### hdl/ufp_pkg.sv
// package for the feedback frame parser: frame geometry, reset values and shared types
// no dependencies; imported by every ufp module and by the top level
`default_nettype none

package ufp_pkg;

  localparam int unsigned FrameLen       = 18;
  localparam int unsigned WordCount      = FrameLen / 2;
  localparam int unsigned IdxW           = $clog2(FrameLen + 1);
  localparam logic [15:0] StartWordReset = 16'hABCD;

  // one received byte moving from the input register to the frame logic
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } ufp_byte_t;

  // payload words, first received field (command_one) in the lowest bits
  typedef struct packed {
    logic        [15:0] led_command;
    logic signed [15:0] board_temperature;
    logic signed [15:0] battery_voltage;
    logic signed [15:0] speed_left_meas;
    logic signed [15:0] speed_right;
    logic signed [15:0] command_two;
    logic signed [15:0] command_one;
  } ufp_payload_t;

  typedef struct packed {
    logic         valid;
    ufp_payload_t payload;
  } ufp_result_t;

endpackage

`default_nettype wire

### hdl/ufp_in_stage.sv
// input register of the frame parser: holds one accepted byte until the frame logic takes it
// depends on ufp_pkg
`default_nettype none

module ufp_in_stage
  import ufp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       tvalid_i,
  output logic            tready_o,
  input  wire logic [7:0] tdata_i,
  input  wire logic       adv_i,
  output ufp_byte_t       byte_o
);

  logic       valid_q;
  logic       valid_d;
  logic [7:0] data_q;

  // free when empty or when the held byte moves on this cycle
  assign tready_o = !valid_q || adv_i;
  assign valid_d  = tready_o ? tvalid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tvalid_i && tready_o) begin
      data_q <= tdata_i;
    end
  end

  assign byte_o.valid = valid_q;
  assign byte_o.data  = data_q;

endmodule

`default_nettype wire

### hdl/ufp_frame.sv
// frame state of the parser: start word detect, byte buffer, index and checksum check
// depends on ufp_pkg
`default_nettype none

module ufp_frame
  import ufp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire ufp_byte_t   byte_i,
  input  wire logic        adv_i,
  output ufp_result_t      res_o
);

  localparam logic [IdxW-1:0] IdxFirst = IdxW'(2);
  localparam logic [IdxW-1:0] IdxLast  = IdxW'(FrameLen - 1);

  logic [15:0]     start_q;
  logic [7:0]      prev_q;
  logic [IdxW-1:0] idx_q;
  logic [IdxW-1:0] idx_d;
  logic [7:0]      bytes_q [FrameLen];

  logic [7:0]  cur;
  logic [15:0] pair;
  logic        process;
  logic        hit;
  logic        append;
  logic        done;
  logic [15:0] xor_sum;
  logic [15:0] w0;
  logic [15:0] w8;

  assign cur     = byte_i.data;
  assign pair    = {cur, prev_q};
  assign process = adv_i && byte_i.valid;
  assign hit     = (pair == start_q);
  assign append  = !hit && (idx_q >= IdxFirst) && (idx_q <= IdxLast);
  assign done    = append && (idx_q == IdxLast);

  // checksum over words 0..7, all already stored when the last byte arrives
  always_comb begin
    xor_sum = '0;
    for (int k = 0; k < WordCount - 1; k++) begin
      xor_sum = xor_sum ^ {bytes_q[2*k+1], bytes_q[2*k]};
    end
  end

  assign w0 = {bytes_q[1], bytes_q[0]};
  assign w8 = {cur, bytes_q[FrameLen-2]};

  always_comb begin
    idx_d = idx_q;
    if (process) begin
      priority if (hit) begin
        idx_d = IdxFirst;
      end else if (done) begin
        idx_d = '0;
      end else if (append) begin
        idx_d = idx_q + IdxW'(1);
      end else begin
        // byte outside a frame leaves the index idle
        idx_d = idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= StartWordReset;
      prev_q  <= '0;
      idx_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        start_q <= cfg_wdata_i;
      end
      if (process) begin
        prev_q <= cur;
      end
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      if (hit) begin
        bytes_q[0] <= prev_q;
        bytes_q[1] <= cur;
      end else if (append) begin
        bytes_q[idx_q] <= cur;
      end
    end
  end

  assign res_o.valid = process && done && (w0 == start_q) && (xor_sum == w8);
  assign res_o.payload.command_one       = {bytes_q[3], bytes_q[2]};
  assign res_o.payload.command_two       = {bytes_q[5], bytes_q[4]};
  assign res_o.payload.speed_right       = {bytes_q[7], bytes_q[6]};
  assign res_o.payload.speed_left_meas   = {bytes_q[9], bytes_q[8]};
  assign res_o.payload.battery_voltage   = {bytes_q[11], bytes_q[10]};
  assign res_o.payload.board_temperature = {bytes_q[13], bytes_q[12]};
  assign res_o.payload.led_command       = {bytes_q[15], bytes_q[14]};

  // index is idle or counts collected bytes
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q == '0) || ((idx_q >= IdxFirst) && (idx_q <= IdxLast)))
    else $error("frame index out of range");

  // a result only comes with the last byte of a frame
  a_res_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (idx_q == IdxLast) && !hit)
    else $error("result without a complete frame");

  // start word always restarts the frame
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && hit) |=> (idx_q == IdxFirst))
    else $error("start word did not restart the frame");

  // a completed frame always returns to idle
  a_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && done) |=> (idx_q == '0))
    else $error("frame not closed after last byte");

endmodule

`default_nettype wire

### hdl/ufp_out_stage.sv
// output register of the frame parser: holds one decoded frame until the receiver takes it
// depends on ufp_pkg
`default_nettype none

module ufp_out_stage
  import ufp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ufp_result_t res_i,
  output logic             adv_o,
  output logic             tvalid_o,
  input  wire logic        tready_i,
  output ufp_payload_t     tdata_o
);

  logic         valid_q;
  logic         valid_d;
  ufp_payload_t data_q;

  // the frame logic may step when the register is empty or drains now
  assign adv_o   = !valid_q || tready_i;
  assign valid_d = adv_o ? res_i.valid : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && res_i.valid) begin
      data_q <= res_i.payload;
    end
  end

  assign tvalid_o = valid_q;
  assign tdata_o  = data_q;

endmodule

`default_nettype wire

### hdl/uart_feedback_frame_parser.sv
// top level of the feedback frame parser: byte stream in, decoded frame words out
// depends on ufp_pkg, ufp_in_stage, ufp_frame and ufp_out_stage
//
// usage
//   s_axis carries one received serial byte per transaction in tdata[7:0]
//   m_axis carries one transaction per valid frame: seven 16-bit words
//   cfg_we_i / cfg_wdata_i write the 16-bit start word (low byte received first),
//   reset value 0xABCD; write only while no byte is in flight
//   a frame is the start word plus 16 more bytes; it is passed on when its first
//   word matches the start word and the xor of words 0..7 equals word 8, else dropped
//   a start word seen anywhere restarts the frame
// timing
//   one byte per cycle sustained while m_axis is not stalled; the last byte of a
//   frame goes through the input register, then the frame logic, whose result is
//   registered into the output register
// reset
//   asynchronous, active low; clears both valid flags, the frame index, the last
//   byte and restores the start word; the frame buffer is not cleared
// stall
//   while m_axis is stalled with a result held, the frame logic pauses, one more
//   byte waits in the input register and s_axis_tready then drops
`default_nettype none

module uart_feedback_frame_parser
  import ufp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [15:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [15:0] command_one, [31:16] command_two, [47:32] speed_right,
  // [63:48] speed_left_meas, [79:64] battery_voltage,
  // [95:80] board_temperature, [111:96] led_command
  output logic [111:0]      m_axis_tdata
);

  ufp_byte_t    in_byte;
  ufp_result_t  result;
  ufp_payload_t out_payload;
  logic         adv;

  // input register, parts the byte stream from the frame logic
  ufp_in_stage u_in (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tvalid_i (s_axis_tvalid),
    .tready_o (s_axis_tready),
    .tdata_i  (s_axis_tdata),
    .adv_i    (adv),
    .byte_o   (in_byte)
  );

  // start detection, buffer, index and checksum
  ufp_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .byte_i      (in_byte),
    .adv_i       (adv),
    .res_o       (result)
  );

  // result register toward the receiver
  ufp_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .res_i    (result),
    .adv_o    (adv),
    .tvalid_o (m_axis_tvalid),
    .tready_i (m_axis_tready),
    .tdata_o  (out_payload)
  );

  assign m_axis_tdata = out_payload;

endmodule

`default_nettype wire

### verif/uart_feedback_frame_parser_tb.sv
// testbench for uart_feedback_frame_parser: byte stream in, checked frame words out
// depends on ufp_pkg and the parser rtl; self-checking, needs no files or arguments
module uart_feedback_frame_parser_tb;
  import ufp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DrainCycles = 8;
  localparam int unsigned IdlePct     = 11;

  logic         clk_i          = 1'b0;
  logic         rst_ni         = 1'b0;
  logic         cfg_we_i       = 1'b0;
  logic [15:0]  cfg_wdata_i    = '0;
  logic         s_axis_tvalid  = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata   = '0;   // [7:0] rx_byte
  logic         m_axis_tvalid;
  logic         m_axis_tready  = 1'b0;
  // [15:0] command_one, [31:16] command_two, [47:32] speed_right,
  // [63:48] speed_left_meas, [79:64] battery_voltage,
  // [95:80] board_temperature, [111:96] led_command
  logic [111:0] m_axis_tdata;

  // when set, neither side idles
  bit           steady_traffic = 1'b0;
  int unsigned  error_count    = 0;
  int unsigned  framed_bytes   = 0;

  // own copy of the parser state, advanced on every accepted byte transaction
  logic [15:0]  start_marker   = StartWordReset;
  logic [7:0]   rx_prev        = '0;
  int unsigned  frame_fill     = 0;
  logic [7:0]   frame_buf [FrameLen];

  // payloads of frames that passed the marker and xor checks, oldest first
  ufp_payload_t pending_payloads [$];

  uart_feedback_frame_parser uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // receiver back-pressure, random except during the steady stretch
  always @(posedge clk_i) begin
    m_axis_tready <= steady_traffic || ($urandom_range(99) >= IdlePct);
  end

  // ---------------------------------------------------------------------------
  // frame prediction
  // ---------------------------------------------------------------------------

  // one received byte: start word detection, frame fill, and the frame check
  task automatic decode_feedback_byte(input logic [7:0] rx);
    logic [15:0]  xor_sum;
    logic [111:0] words;
    if ({rx, rx_prev} == start_marker) begin
      // start word restarts the frame, even in the middle of one
      frame_buf[0] = rx_prev;
      frame_buf[1] = rx;
      frame_fill   = 2;
    end else if (frame_fill >= 2 && frame_fill < FrameLen) begin
      frame_buf[frame_fill] = rx;
      frame_fill++;
    end
    // bytes outside a frame only update the previous byte
    if (frame_fill == FrameLen) begin
      xor_sum = '0;
      for (int k = 0; k < WordCount - 1; k++) begin
        xor_sum ^= {frame_buf[2*k+1], frame_buf[2*k]};
      end
      // first word is compared with the marker in force now, not at frame start
      if ({frame_buf[1], frame_buf[0]} == start_marker &&
          xor_sum == {frame_buf[FrameLen-1], frame_buf[FrameLen-2]}) begin
        for (int k = 1; k < WordCount - 1; k++) begin
          words[16*(k-1) +: 16] = {frame_buf[2*k+1], frame_buf[2*k]};
        end
        pending_payloads.push_back(ufp_payload_t'(words));
      end
      // a rejected frame is dropped silently
      frame_fill = 0;
    end
    rx_prev = rx;
  endtask

  task automatic compare_word(input string field, input logic [15:0] want,
                              input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", field, want, got);
      error_count++;
    end
  endtask

  task automatic check_payload(input ufp_payload_t got);
    ufp_payload_t want;
    if (pending_payloads.size() == 0) begin
      $error("frame result with none pending: %h", got);
      error_count++;
    end else begin
      want = pending_payloads.pop_front();
      compare_word("command_one", want.command_one, got.command_one);
      compare_word("command_two", want.command_two, got.command_two);
      compare_word("speed_right", want.speed_right, got.speed_right);
      compare_word("speed_left_meas", want.speed_left_meas, got.speed_left_meas);
      compare_word("battery_voltage", want.battery_voltage, got.battery_voltage);
      compare_word("board_temperature", want.board_temperature, got.board_temperature);
      compare_word("led_command", want.led_command, got.led_command);
    end
  endtask

  // all sampling happens at the edge, before any nonblocking update lands
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        start_marker = cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        decode_feedback_byte(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_payload(ufp_payload_t'(m_axis_tdata));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one byte transaction; tvalid stays high on return so back-to-back bytes
  // never see a low and a high in the same step
  task automatic send_byte(input logic [7:0] rx);
    while (!steady_traffic && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rx;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // bytes first..stop-1 of a frame built from marker and payload, low byte first;
  // bad_sum flips one bit of the xor word
  task automatic send_frame(input logic [15:0] marker, input logic [111:0] words,
                            input bit bad_sum, input int unsigned first,
                            input int unsigned stop);
    logic [15:0] w [WordCount];
    w[0] = marker;
    for (int k = 1; k < WordCount - 1; k++) begin
      w[k] = words[16*(k-1) +: 16];
    end
    w[WordCount-1] = '0;
    for (int k = 0; k < WordCount - 1; k++) begin
      w[WordCount-1] ^= w[k];
    end
    if (bad_sum) begin
      w[WordCount-1] ^= 16'(1 << $urandom_range(15));
    end
    for (int i = first; i < stop; i++) begin
      send_byte(i[0] ? w[i/2][15:8] : w[i/2][7:0]);
      framed_bytes++;
    end
  endtask

  // payload words, a fair share of them at the signed and unsigned extremes
  function automatic logic [111:0] random_payload();
    logic [111:0] words;
    for (int k = 0; k < WordCount - 2; k++) begin
      case ($urandom_range(9))
        0: words[16*k +: 16] = 16'h0000;
        1: words[16*k +: 16] = 16'hFFFF;
        2: words[16*k +: 16] = 16'h8000;
        3: words[16*k +: 16] = 16'h7FFF;
        default: words[16*k +: 16] = 16'($urandom);
      endcase
    end
    return words;
  endfunction

  // stop sending and wait until every pending frame result has come out
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_payloads.size() != 0);
    // a dropped frame leaves no result to wait for, so let the pipeline empty
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // only called while idle
  task automatic write_start_word(input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset marker: stray bytes, extreme payload, bad xor, restart inside a frame
  task automatic test_frames_at_reset_marker();
    // no frame open yet, so these are ignored
    send_byte(8'h00);
    send_byte(8'hCD);
    send_byte(8'h12);
    send_frame(StartWordReset,
               {16'hFFFF, 16'h0001, 16'hFFFE, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000},
               1'b0, 0, FrameLen);
    send_frame(StartWordReset, random_payload(), 1'b1, 0, FrameLen);
    // start word part way through abandons the open frame
    send_frame(StartWordReset, random_payload(), 1'b0, 0, 9);
    send_frame(StartWordReset,
               {16'h0000, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, 16'h8001, 16'h7FFE},
               1'b0, 0, FrameLen);
    wait_idle();
  endtask

  // sender holds off mid-frame until all results are out, then the marker changes;
  // the old frame then fails its first-word check
  task automatic test_marker_change_mid_frame();
    logic [111:0] words;
    words = random_payload();
    send_frame(StartWordReset, words, 1'b0, 0, 7);
    wait_idle();
    write_start_word(16'h5A3C);
    send_frame(StartWordReset, words, 1'b0, 7, FrameLen);
    send_frame(16'h5A3C, random_payload(), 1'b0, 0, FrameLen);
    wait_idle();
  endtask

  // all-zero and all-ones markers; a run of equal bytes keeps restarting
  task automatic test_marker_extremes();
    write_start_word(16'h0000);
    send_frame(16'h0000, {7{16'h8001}}, 1'b0, 0, FrameLen);
    send_byte(8'h00);
    send_byte(8'h00);
    send_frame(16'h0000, {7{16'h0102}}, 1'b0, 0, FrameLen);
    wait_idle();
    write_start_word(16'hFFFF);
    repeat (5) send_byte(8'hFF);
    send_frame(16'hFFFF, {7{16'h7FFE}}, 1'b0, 0, FrameLen);
    wait_idle();
  endtask

  // mostly good frames with random content, plus bad xor, cut frames and noise
  task automatic test_random_traffic(input logic [15:0] marker,
                                     input int unsigned n_bytes);
    int unsigned base;
    int unsigned pick;
    base = framed_bytes;
    write_start_word(marker);
    while (framed_bytes - base < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_frame(marker, random_payload(), 1'b0, 0, FrameLen);
      end else if (pick < 80) begin
        send_frame(marker, random_payload(), 1'b1, 0, FrameLen);
      end else if (pick < 90) begin
        send_frame(marker, random_payload(), 1'b0, 0, $urandom_range(FrameLen - 1, 2));
      end else begin
        repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_frames_at_reset_marker();
    test_marker_change_mid_frame();
    test_marker_extremes();
    test_random_traffic(StartWordReset, 220);
    steady_traffic = 1'b1;
    test_random_traffic(16'($urandom), 260);
    steady_traffic = 1'b0;
    test_random_traffic(16'h0000, 210);
    test_random_traffic(16'hFFFF, 210);
    test_random_traffic(16'($urandom), 210);

    if (error_count == 0 && pending_payloads.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #(2_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### uart_feedback_frame_parser.f
hdl/ufp_pkg.sv
hdl/ufp_in_stage.sv
hdl/ufp_frame.sv
hdl/ufp_out_stage.sv
hdl/uart_feedback_frame_parser.sv
verif/uart_feedback_frame_parser_tb.sv
